>>> src/sprite_frame_sequencer_top_assert.svh
// Assertion macros shared by the sprite frame sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTH

`define SFS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sprite frame sequencer: same-cycle check failed");

`define SFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sprite frame sequencer: next-cycle check failed");

`else

`define SFS_ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define SFS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> src/sfs_pkg.sv
// Types, constants and width functions shared by the sprite frame sequencer.
`default_nettype none

package sfs_pkg;

    localparam int unsigned DEF_MAX_ACROSS = 16;
    localparam int unsigned DEF_MAX_DOWN = 16;
    localparam int unsigned DEF_TIME_WIDTH = 16;

    localparam int unsigned DIM_LIMIT = 31;
    localparam int unsigned RANGE_ORDER_MAX = 510;
    localparam int unsigned FRAME_FIELD_MAX = 255;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PIX_W = 14;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_ACROSS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_DOWN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_FIRST = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LAST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAY_FLAGS = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_FRAME = 3'd7;

    localparam logic [2:0] MODE_TICK = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP = 3'd2;
    localparam logic [2:0] MODE_PAUSE = 3'd3;
    localparam logic [2:0] MODE_RESUME = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] elapsed;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       frame_index;
        logic [PIX_W-1:0] frame_x;
        logic [PIX_W-1:0] frame_y;
        logic             playing;
        logic             done_res;
    } out_item_t;

    typedef struct packed {
        logic add;
        logic adv;
        logic map;
    } play_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_ADV,
        ST_MAP,
        ST_LAUNCH,
        ST_CALC,
        ST_HOLD
    } seq_state_t;

    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_DIV,
        CALC_MULX,
        CALC_MULY
    } calc_phase_t;

    function automatic int unsigned dim_cap(input int unsigned m);
        return (m < DIM_LIMIT) ? m : DIM_LIMIT;
    endfunction

    function automatic int unsigned dim_w(input int unsigned m);
        return $clog2(dim_cap(m) + 1);
    endfunction

    function automatic int unsigned sheet_max(input int unsigned ma, input int unsigned md);
        return dim_cap(ma) * dim_cap(md);
    endfunction

    function automatic int unsigned sheet_w(input int unsigned ma, input int unsigned md);
        return $clog2(sheet_max(ma, md) + 1);
    endfunction

    function automatic int unsigned order_max(input int unsigned ma, input int unsigned md);
        return (2 * sheet_max(ma, md) > RANGE_ORDER_MAX) ? 2 * sheet_max(ma, md)
                                                         : RANGE_ORDER_MAX;
    endfunction

    function automatic int unsigned order_w(input int unsigned ma, input int unsigned md);
        return $clog2(order_max(ma, md) + 1);
    endfunction

    function automatic int unsigned pos_w(input int unsigned ma, input int unsigned md);
        return $clog2(order_max(ma, md));
    endfunction

    function automatic int unsigned frame_w(input int unsigned ma, input int unsigned md);
        return $clog2(((sheet_max(ma, md) - 1 > FRAME_FIELD_MAX) ? sheet_max(ma, md) - 1
                                                                  : FRAME_FIELD_MAX) + 1);
    endfunction

endpackage

`default_nettype wire

>>> src/sfs_cfg_regs.sv
// Configuration registers with the clamped sheet size and play order length.
`default_nettype none

module sfs_cfg_regs #(
    parameter int unsigned MAX_ACROSS = sfs_pkg::DEF_MAX_ACROSS,
    parameter int unsigned MAX_DOWN = sfs_pkg::DEF_MAX_DOWN
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  cfg_valid,
    output logic                                                  cfg_ready,
    input  logic [sfs_pkg::CFG_INDEX_W-1:0]                       cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]                        cfg_data,
    output logic [sfs_pkg::dim_w(MAX_ACROSS)-1:0]                 across,
    output logic [sfs_pkg::sheet_w(MAX_ACROSS, MAX_DOWN)-1:0]     n_frames,
    output logic [sfs_pkg::order_w(MAX_ACROSS, MAX_DOWN)-1:0]     order_len,
    output logic [7:0]                                            range_first,
    output logic [7:0]                                            range_last,
    output logic                                                  loop_en,
    output logic                                                  range_mode,
    output logic [15:0]                                           ticks_per_frame,
    output logic [9:0]                                            cell_width,
    output logic [9:0]                                            cell_height
);
    import sfs_pkg::*;

    localparam int unsigned ACAP = dim_cap(MAX_ACROSS);
    localparam int unsigned DCAP = dim_cap(MAX_DOWN);
    localparam int unsigned AW = dim_w(MAX_ACROSS);
    localparam int unsigned DW = dim_w(MAX_DOWN);
    localparam int unsigned NW = sheet_w(MAX_ACROSS, MAX_DOWN);
    localparam int unsigned LW = order_w(MAX_ACROSS, MAX_DOWN);

    logic [4:0]   frames_across_reg;
    logic [4:0]   frames_down_reg;
    logic [9:0]   cell_width_reg;
    logic [9:0]   cell_height_reg;
    logic [7:0]   range_first_reg;
    logic [7:0]   range_last_reg;
    logic [2:0]   play_flags_reg;
    logic [15:0]  ticks_reg;
    logic         cfg_we;
    logic [4:0]   across_c;
    logic [4:0]   down_c;
    logic [DW-1:0] down;
    logic [AW+DW-1:0] sheet_prod;
    logic [7:0]   range_span;

    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_across_reg <= 5'd1;
            frames_down_reg <= 5'd1;
            cell_width_reg <= 10'd1;
            cell_height_reg <= 10'd1;
            range_first_reg <= 8'd0;
            range_last_reg <= 8'd0;
            play_flags_reg <= 3'd0;
            ticks_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAMES_ACROSS:   frames_across_reg <= cfg_data[4:0];
                REG_FRAMES_DOWN:     frames_down_reg <= cfg_data[4:0];
                REG_CELL_WIDTH:      cell_width_reg <= cfg_data[9:0];
                REG_CELL_HEIGHT:     cell_height_reg <= cfg_data[9:0];
                REG_RANGE_FIRST:     range_first_reg <= cfg_data[7:0];
                REG_RANGE_LAST:      range_last_reg <= cfg_data[7:0];
                REG_PLAY_FLAGS:      play_flags_reg <= cfg_data[2:0];
                REG_TICKS_PER_FRAME: ticks_reg <= cfg_data[15:0];
            endcase
        end
    end

    always_comb
    begin
        if (frames_across_reg == 5'd0)
            across_c = 5'd1;
        else if (frames_across_reg > 5'(ACAP))
            across_c = 5'(ACAP);
        else
            across_c = frames_across_reg;

        if (frames_down_reg == 5'd0)
            down_c = 5'd1;
        else if (frames_down_reg > 5'(DCAP))
            down_c = 5'(DCAP);
        else
            down_c = frames_down_reg;
    end

    assign across = AW'(across_c);
    assign down = DW'(down_c);
    assign sheet_prod = (AW+DW)'(across) * (AW+DW)'(down);
    assign n_frames = sheet_prod[NW-1:0];

    assign range_span = (range_first_reg > range_last_reg) ? range_first_reg - range_last_reg
                                                           : range_last_reg - range_first_reg;

    always_comb
    begin
        if (play_flags_reg[2])
        begin
            if (play_flags_reg[0] && (range_span != 8'd0))
                order_len = LW'({range_span, 1'b0});
            else
                order_len = LW'(range_span) + LW'(1);
        end
        else if (play_flags_reg[0])
            order_len = LW'({n_frames, 1'b0});
        else
            order_len = LW'(n_frames);
    end

    assign range_first = range_first_reg;
    assign range_last = range_last_reg;
    assign loop_en = play_flags_reg[1];
    assign range_mode = play_flags_reg[2];
    assign ticks_per_frame = ticks_reg;
    assign cell_width = cell_width_reg;
    assign cell_height = cell_height_reg;

endmodule

`default_nettype wire

>>> src/sfs_play.sv
// Play position, time accumulator and running flag, with the frame lookup.
`default_nettype none

module sfs_play #(
    parameter int unsigned MAX_ACROSS = sfs_pkg::DEF_MAX_ACROSS,
    parameter int unsigned MAX_DOWN = sfs_pkg::DEF_MAX_DOWN,
    parameter int unsigned TIME_WIDTH = sfs_pkg::DEF_TIME_WIDTH
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  sfs_pkg::play_ctrl_t                                   ctrl,
    input  logic [2:0]                                            mode,
    input  logic [15:0]                                           elapsed,
    input  logic [sfs_pkg::sheet_w(MAX_ACROSS, MAX_DOWN)-1:0]     n_frames,
    input  logic [sfs_pkg::order_w(MAX_ACROSS, MAX_DOWN)-1:0]     order_len,
    input  logic [7:0]                                            range_first,
    input  logic [7:0]                                            range_last,
    input  logic                                                  loop_en,
    input  logic                                                  range_mode,
    input  logic [15:0]                                           ticks_per_frame,
    output logic [sfs_pkg::frame_w(MAX_ACROSS, MAX_DOWN)-1:0]     frame,
    output logic                                                  running,
    output logic                                                  done
);
    import sfs_pkg::*;

    localparam int unsigned LW = order_w(MAX_ACROSS, MAX_DOWN);
    localparam int unsigned POSW = pos_w(MAX_ACROSS, MAX_DOWN);
    localparam int unsigned FW = frame_w(MAX_ACROSS, MAX_DOWN);
    localparam int unsigned TAW = TIME_WIDTH + 1;
    localparam int unsigned CW = (TAW > 16) ? TAW : 16;
    localparam int unsigned SW = CW + 1;

    logic [POSW-1:0] pos_reg, pos_next;
    logic [TAW-1:0]  acc_reg, acc_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [FW-1:0]   frame_reg, frame_next;

    logic [SW-1:0]   sum;
    logic [TAW-1:0]  acc_sat;
    logic            acc_ge;
    logic [CW-1:0]   acc_diff;
    logic [LW:0]     pos_inc;
    logic [LW:0]     len_x;
    logic [LW-1:0]   len_m1;
    logic [LW-1:0]   p_l;
    logic [LW-1:0]   n_l;
    logic [LW-1:0]   nm1;
    logic [LW-1:0]   e_l;
    logic [LW-1:0]   f_full;
    logic [LW-1:0]   f_sel;
    logic [LW-1:0]   f_clamp;
    logic [7:0]      range_span;
    logic            a_gt_b;
    logic [7:0]      f_rng;

    always_comb
    begin
        sum = SW'(acc_reg) + SW'(elapsed);
        acc_sat = (|sum[SW-1:TAW]) ? '1 : sum[TAW-1:0];
        acc_ge = CW'(acc_reg) >= CW'(ticks_per_frame);
        acc_diff = CW'(acc_reg) - CW'(ticks_per_frame);
        pos_inc = (LW+1)'(pos_reg) + (LW+1)'(1);
        len_x = (LW+1)'(order_len);
        len_m1 = order_len - LW'(1);

        p_l = (LW'(pos_reg) >= order_len) ? len_m1 : LW'(pos_reg);
        n_l = LW'(n_frames);
        nm1 = n_l - LW'(1);
        f_full = (p_l < n_l) ? p_l : LW'({n_frames, 1'b0}) - LW'(1) - p_l;

        a_gt_b = range_first > range_last;
        range_span = a_gt_b ? range_first - range_last : range_last - range_first;
        e_l = p_l - LW'(range_span);
        if (p_l <= LW'(range_span))
            f_rng = a_gt_b ? range_first - p_l[7:0] : range_first + p_l[7:0];
        else
            f_rng = a_gt_b ? range_last + e_l[7:0] : range_last - e_l[7:0];

        f_sel = range_mode ? LW'(f_rng) : f_full;
        f_clamp = (f_sel > nm1) ? nm1 : f_sel;
    end

    always_comb
    begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        run_next = run_reg;
        done_next = done_reg;
        frame_next = frame_reg;

        if (ctrl.add)
        begin
            done_next = 1'b0;
            unique case (mode)
                MODE_TICK:
                begin
                    if (run_reg)
                        acc_next = acc_sat;
                end
                MODE_START:
                begin
                    run_next = 1'b1;
                    pos_next = '0;
                end
                MODE_STOP:
                begin
                    run_next = 1'b0;
                    pos_next = '0;
                end
                MODE_PAUSE:  run_next = 1'b0;
                MODE_RESUME: run_next = 1'b1;
                default:     ;
            endcase
        end

        if (ctrl.adv && (mode == MODE_TICK) && run_reg && acc_ge)
        begin
            acc_next = acc_diff[TAW-1:0];
            if (pos_inc >= len_x)
            begin
                if (loop_en)
                    pos_next = '0;
                else
                begin
                    pos_next = len_m1[POSW-1:0];
                    run_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
                pos_next = pos_inc[POSW-1:0];
        end

        if (ctrl.map)
            frame_next = f_clamp[FW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            acc_reg <= '0;
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame = frame_reg;
    assign running = run_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> src/sfs_calc.sv
// Shared iterative unit: restoring divide by the column count, then two pixel multiplies.
`default_nettype none

module sfs_calc #(
    parameter int unsigned MAX_ACROSS = sfs_pkg::DEF_MAX_ACROSS,
    parameter int unsigned MAX_DOWN = sfs_pkg::DEF_MAX_DOWN
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  start,
    input  logic [sfs_pkg::frame_w(MAX_ACROSS, MAX_DOWN)-1:0]     dividend,
    input  logic [sfs_pkg::dim_w(MAX_ACROSS)-1:0]                 divisor,
    input  logic [9:0]                                            cell_width,
    input  logic [9:0]                                            cell_height,
    output logic                                                  done,
    output logic [sfs_pkg::PIX_W-1:0]                             frame_x,
    output logic [sfs_pkg::PIX_W-1:0]                             frame_y
);
    import sfs_pkg::*;

    localparam int unsigned FW = frame_w(MAX_ACROSS, MAX_DOWN);
    localparam int unsigned AW = dim_w(MAX_ACROSS);
    localparam int unsigned CNTW = $clog2(FW + 1);
    localparam int unsigned PW = FW + 10;

    calc_phase_t     phase_reg, phase_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [AW-1:0]   rem_reg, rem_next;
    logic [FW-1:0]   quo_reg, quo_next;
    logic [PIX_W-1:0] x_reg, x_next;
    logic [PIX_W-1:0] y_reg, y_next;

    logic [AW:0]     trial;
    logic [AW:0]     diff;
    logic            fit;
    logic [FW-1:0]   mul_a;
    logic [9:0]      mul_b;
    logic [PW-1:0]   prod;
    logic [PIX_W-1:0] prod_sat;

    always_comb
    begin
        trial = {rem_reg, quo_reg[FW-1]};
        fit = trial >= {1'b0, divisor};
        diff = trial - {1'b0, divisor};
        mul_a = (phase_reg == CALC_MULX) ? FW'(rem_reg) : quo_reg;
        mul_b = (phase_reg == CALC_MULX) ? cell_width : cell_height;
        prod = PW'(mul_a) * PW'(mul_b);
        prod_sat = (|prod[PW-1:PIX_W]) ? PIX_MAX : prod[PIX_W-1:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        rem_next = rem_reg;
        quo_next = quo_reg;
        x_next = x_reg;
        y_next = y_reg;

        unique case (phase_reg)
            CALC_IDLE:
            begin
                if (start)
                begin
                    rem_next = '0;
                    quo_next = dividend;
                    cnt_next = CNTW'(FW);
                    phase_next = CALC_DIV;
                end
            end
            CALC_DIV:
            begin
                rem_next = fit ? diff[AW-1:0] : trial[AW-1:0];
                quo_next = {quo_reg[FW-2:0], fit};
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                    phase_next = CALC_MULX;
            end
            CALC_MULX:
            begin
                x_next = prod_sat;
                phase_next = CALC_MULY;
            end
            CALC_MULY:
            begin
                y_next = prod_sat;
                done_next = 1'b1;
                phase_next = CALC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= CALC_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign done = done_reg;
    assign frame_x = x_reg;
    assign frame_y = y_reg;

endmodule

`default_nettype wire

>>> src/sprite_frame_sequencer_top.sv
// Top level of the sprite frame sequencer: command sequencer and result register.
//
// Commands arrive on cmd with cmd_valid; the block raises cmd_stall while it is
// working on an item. An item is taken at a clock edge with cmd_valid high and
// cmd_stall low. Each command item produces exactly one result item on res.
// A result is taken at a clock edge with res_valid high and res_stall low.
// The divide of the frame index by the column count runs one quotient bit per
// cycle through the shared unit, followed by a multiply for x and one for y.
// Each item passes through the update, launch, calculate, handoff and load
// steps before the block takes the next command.
// The result register lets the next command be taken while a result waits.
// When res_stall is held, a finished result waits in the shared unit and the
// block takes no new command until the result register frees up.
// Configuration writes on cfg are always ready; the user is to make them
// between items, as the block itself does not enforce this.
// Reset clears the play position, accumulator and running flag, and loads
// every configuration register with its reset value.
`default_nettype none

module sprite_frame_sequencer_top #(
    parameter int unsigned MAX_ACROSS = sfs_pkg::DEF_MAX_ACROSS,
    parameter int unsigned MAX_DOWN = sfs_pkg::DEF_MAX_DOWN,
    parameter int unsigned TIME_WIDTH = sfs_pkg::DEF_TIME_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  sfs_pkg::in_item_t               cmd,
    output logic                            res_valid,
    input  logic                            res_stall,
    output sfs_pkg::out_item_t              res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfs_pkg::*;

    `include "sprite_frame_sequencer_top_assert.svh"

    localparam int unsigned AW = dim_w(MAX_ACROSS);
    localparam int unsigned NW = sheet_w(MAX_ACROSS, MAX_DOWN);
    localparam int unsigned LW = order_w(MAX_ACROSS, MAX_DOWN);
    localparam int unsigned FW = frame_w(MAX_ACROSS, MAX_DOWN);

    seq_state_t  state_reg, state_next;
    in_item_t    cmd_reg;
    logic        res_valid_reg, res_valid_next;
    out_item_t   res_reg;

    play_ctrl_t  ctrl;
    logic        calc_start;
    logic        calc_done;
    logic        res_load;
    logic        slot_free;
    logic        cmd_take;

    logic [AW-1:0] across;
    logic [NW-1:0] n_frames;
    logic [LW-1:0] order_len;
    logic [7:0]    range_first;
    logic [7:0]    range_last;
    logic          loop_en;
    logic          range_mode;
    logic [15:0]   ticks_per_frame;
    logic [9:0]    cell_width;
    logic [9:0]    cell_height;
    logic [FW-1:0] frame;
    logic          running;
    logic          done;
    logic [PIX_W-1:0] frame_x;
    logic [PIX_W-1:0] frame_y;

    sfs_cfg_regs #(
        .MAX_ACROSS(MAX_ACROSS),
        .MAX_DOWN(MAX_DOWN)
    ) u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .across(across),
        .n_frames(n_frames),
        .order_len(order_len),
        .range_first(range_first),
        .range_last(range_last),
        .loop_en(loop_en),
        .range_mode(range_mode),
        .ticks_per_frame(ticks_per_frame),
        .cell_width(cell_width),
        .cell_height(cell_height)
    );

    sfs_play #(
        .MAX_ACROSS(MAX_ACROSS),
        .MAX_DOWN(MAX_DOWN),
        .TIME_WIDTH(TIME_WIDTH)
    ) u_play (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(ctrl),
        .mode(cmd_reg.mode),
        .elapsed(cmd_reg.elapsed),
        .n_frames(n_frames),
        .order_len(order_len),
        .range_first(range_first),
        .range_last(range_last),
        .loop_en(loop_en),
        .range_mode(range_mode),
        .ticks_per_frame(ticks_per_frame),
        .frame(frame),
        .running(running),
        .done(done)
    );

    sfs_calc #(
        .MAX_ACROSS(MAX_ACROSS),
        .MAX_DOWN(MAX_DOWN)
    ) u_calc (
        .clk(clk),
        .rst_n(rst_n),
        .start(calc_start),
        .dividend(frame),
        .divisor(across),
        .cell_width(cell_width),
        .cell_height(cell_height),
        .done(calc_done),
        .frame_x(frame_x),
        .frame_y(frame_y)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take = cmd_valid && !cmd_stall;
    assign slot_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        calc_start = 1'b0;
        res_load = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                ctrl.add = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                ctrl.adv = 1'b1;
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                ctrl.map = 1'b1;
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                calc_start = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (calc_done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res_valid_next = res_load || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            cmd_reg <= cmd;
        if (res_load)
        begin
            res_reg.frame_index <= frame[7:0];
            res_reg.frame_x <= frame_x;
            res_reg.frame_y <= frame_y;
            res_reg.playing <= running;
            res_reg.done_res <= done;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

    `SFS_ASSERT_NEXT(a_take_starts_update, clk, rst_n, cmd_take, state_reg == ST_ADD)
    `SFS_ASSERT_IMPLY(a_calc_done_in_calc, clk, rst_n, calc_done, state_reg == ST_CALC)
    `SFS_ASSERT_IMPLY(a_done_stops_play, clk, rst_n, res_valid && res.done_res, !res.playing)
    `SFS_ASSERT_NEXT(a_hold_fills_slot, clk, rst_n, (state_reg == ST_HOLD) && !res_valid, res_valid)

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sprite frame sequencer with a built-in frame predictor.
module testbench;
    import sfs_pkg::*;

    localparam int unsigned HALF_PERIOD = 5;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned TICK_SAT = (1 << (DEF_TIME_WIDTH + 1)) - 1;
    localparam int unsigned PIX_SAT = (1 << PIX_W) - 1;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned REPORT_LIMIT = 60;
    localparam int unsigned DIRECTED_ITEMS = 25;
    localparam int unsigned TOTAL_ITEMS = 1950;
    localparam logic [2:0] MODE_TOP = '1;
    localparam logic [2:0] FLAG_REVERSE = 3'b001;
    localparam logic [2:0] FLAG_LOOP = 3'b010;
    localparam logic [2:0] FLAG_RANGE = 3'b100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    in_item_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    out_item_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies held by the predictor.
    logic [4:0] sheet_across = 5'd1;
    logic [4:0] sheet_down = 5'd1;
    logic [9:0] cell_w = 10'd1;
    logic [9:0] cell_h = 10'd1;
    logic [7:0] span_first = '0;
    logic [7:0] span_last = '0;
    logic [2:0] play_mode = '0;
    logic [15:0] frame_period = 16'd1;

    int unsigned cur_pos = 0;
    int unsigned tick_acc = 0;
    bit anim_on = 1'b0;

    in_item_t pending[$];
    out_item_t frames_due[$];
    int unsigned cmds_issued = 0;
    int unsigned cmds_taken = 0;
    int unsigned frames_seen = 0;
    int unsigned plays_ended = 0;
    int unsigned cfg_writes = 0;
    int unsigned settings_used = 0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;

    sprite_frame_sequencer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned frame_total();
        return clamp_count(sheet_across, DEF_MAX_ACROSS) * clamp_count(sheet_down, DEF_MAX_DOWN);
    endfunction

    function automatic int unsigned span_dist();
        return (span_first > span_last) ? span_first - span_last : span_last - span_first;
    endfunction

    function automatic int unsigned sequence_len();
        bit rev;
        rev = (play_mode & FLAG_REVERSE) != 0;
        if ((play_mode & FLAG_RANGE) != 0)
        begin
            if (rev && span_dist() > 0)
                return 2 * span_dist();
            return span_dist() + 1;
        end
        return rev ? 2 * frame_total() : frame_total();
    endfunction

    function automatic int unsigned frame_at_pos(input int unsigned p);
        int unsigned n, len, d, f;
        n = frame_total();
        len = sequence_len();
        d = span_dist();
        if (p >= len)
            p = len - 1;
        if ((play_mode & FLAG_RANGE) != 0)
        begin
            if (p <= d)
                f = (span_first > span_last) ? span_first - p : span_first + p;
            else
                f = (span_first > span_last) ? span_last + (p - d) : span_last - (p - d);
        end
        else
        begin
            f = (p < n) ? p : 2 * n - 1 - p;
        end
        return (f > n - 1) ? n - 1 : f;
    endfunction

    function automatic logic [PIX_W-1:0] pixel_sat(input int unsigned v);
        return (v > PIX_SAT) ? PIX_MAX : v[PIX_W-1:0];
    endfunction

    function automatic out_item_t advance_sequencer(input in_item_t c);
        out_item_t r;
        int unsigned across, f;
        bit ended;
        ended = 1'b0;
        case (c.mode)
            MODE_TICK:
            begin
                if (anim_on)
                begin
                    tick_acc = tick_acc + c.elapsed;
                    if (tick_acc > TICK_SAT)
                        tick_acc = TICK_SAT;
                    if (tick_acc >= frame_period)
                    begin
                        tick_acc = tick_acc - frame_period;
                        cur_pos++;
                        if (cur_pos >= sequence_len())
                        begin
                            if ((play_mode & FLAG_LOOP) != 0)
                            begin
                                cur_pos = 0;
                            end
                            else
                            begin
                                cur_pos = sequence_len() - 1;
                                anim_on = 1'b0;
                                ended = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_START:
            begin
                anim_on = 1'b1;
                cur_pos = 0;
            end
            MODE_STOP:
            begin
                anim_on = 1'b0;
                cur_pos = 0;
            end
            MODE_PAUSE:
                anim_on = 1'b0;
            MODE_RESUME:
                anim_on = 1'b1;
            default:
                ;
        endcase
        across = clamp_count(sheet_across, DEF_MAX_ACROSS);
        f = frame_at_pos(cur_pos);
        r.frame_index = f[7:0];
        r.frame_x = pixel_sat((f % across) * cell_w);
        r.frame_y = pixel_sat((f / across) * cell_h);
        r.playing = anim_on;
        r.done_res = ended;
        if (ended)
            plays_ended++;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_frame(input out_item_t got);
        out_item_t want;
        frames_seen++;
        if (frames_due.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: result %h expected nothing, got a result", $time, got);
        end
        else
        begin
            want = frames_due.pop_front();
            compare_field("frame_index", want.frame_index, got.frame_index);
            compare_field("frame_x", want.frame_x, got.frame_x);
            compare_field("frame_y", want.frame_y, got.frame_y);
            compare_field("playing", want.playing, got.playing);
            compare_field("done_res", want.done_res, got.done_res);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_valid)
            begin
                frames_due = {frames_due, advance_sequencer(cmd)};
                cmds_taken++;
            end
            if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                cmd <= pending.pop_front();
                cmd_valid <= 1'b1;
                cmds_issued++;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_frame(res);
            res_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_item(input logic [2:0] mode, input logic [15:0] elapsed);
        in_item_t c;
        c.mode = mode;
        c.elapsed = elapsed;
        pending = {pending, c};
    endtask

    task automatic wait_idle();
        while (!(pending.size() == 0 && cmds_issued == cmds_taken && frames_due.size() == 0))
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] keep, noise;
        case (idx)
            REG_FRAMES_ACROSS, REG_FRAMES_DOWN:
                keep = 16'h001F;
            REG_CELL_WIDTH, REG_CELL_HEIGHT:
                keep = 16'h03FF;
            REG_RANGE_FIRST, REG_RANGE_LAST:
                keep = 16'h00FF;
            REG_PLAY_FLAGS:
                keep = 16'h0007;
            default:
                keep = 16'hFFFF;
        endcase
        noise = $urandom_range(1) ? 16'($urandom) : '0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= (noise & ~keep) | (val[CFG_DATA_W-1:0] & keep);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FRAMES_ACROSS:
                sheet_across = val[4:0];
            REG_FRAMES_DOWN:
                sheet_down = val[4:0];
            REG_CELL_WIDTH:
                cell_w = val[9:0];
            REG_CELL_HEIGHT:
                cell_h = val[9:0];
            REG_RANGE_FIRST:
                span_first = val[7:0];
            REG_RANGE_LAST:
                span_last = val[7:0];
            REG_PLAY_FLAGS:
                play_mode = val[2:0];
            default:
                frame_period = val[15:0];
        endcase
        cfg_writes++;
    endtask

    task automatic program_sheet(input int unsigned across, input int unsigned down,
                                 input int unsigned w, input int unsigned h,
                                 input int unsigned first, input int unsigned last,
                                 input int unsigned flags, input int unsigned period);
        write_reg(REG_FRAMES_ACROSS, across);
        write_reg(REG_FRAMES_DOWN, down);
        write_reg(REG_CELL_WIDTH, w);
        write_reg(REG_CELL_HEIGHT, h);
        write_reg(REG_RANGE_FIRST, first);
        write_reg(REG_RANGE_LAST, last);
        write_reg(REG_PLAY_FLAGS, flags);
        write_reg(REG_TICKS_PER_FRAME, period);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int unsigned pick_cell();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 25)
            return 1023;
        return $urandom_range(1, 1023);
    endfunction

    function automatic int unsigned pick_span(input int unsigned hi);
        return ($urandom_range(99) < 80) ? $urandom_range(0, hi) : $urandom_range(0, 255);
    endfunction

    function automatic int unsigned pick_dim();
        return ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(0, 31);
    endfunction

    task automatic random_sheet();
        int unsigned across, down, n, span_hi, period, r;
        across = pick_dim();
        down = pick_dim();
        n = clamp_count(across, DEF_MAX_ACROSS) * clamp_count(down, DEF_MAX_DOWN);
        span_hi = (n + 1 > FRAME_FIELD_MAX) ? FRAME_FIELD_MAX : n + 1;
        r = $urandom_range(99);
        if (r < 15)
            period = 0;
        else if (r < 75)
            period = $urandom_range(1, 6);
        else if (r < 90)
            period = $urandom_range(7, 2000);
        else
            period = $urandom_range(2001, 65535);
        program_sheet(across, down, pick_cell(), pick_cell(), pick_span(span_hi),
                      pick_span(span_hi), $urandom_range(0, 7), period);
    endtask

    function automatic in_item_t random_command();
        in_item_t c;
        int unsigned r, span;
        r = $urandom_range(99);
        if (r < 68)
            c.mode = MODE_TICK;
        else if (r < 76)
            c.mode = MODE_START;
        else if (r < 81)
            c.mode = MODE_STOP;
        else if (r < 87)
            c.mode = MODE_PAUSE;
        else if (r < 93)
            c.mode = MODE_RESUME;
        else
            c.mode = 3'($urandom_range(MODE_RESUME + 1, MODE_TOP));
        span = 2 * frame_period + 1;
        if (span > 65535)
            span = 65535;
        r = $urandom_range(99);
        if (r < 10)
            c.elapsed = '0;
        else if (r < 15)
            c.elapsed = '1;
        else if (r < 30)
            c.elapsed = 16'($urandom);
        else
            c.elapsed = 16'($urandom_range(0, span));
        return c;
    endfunction

    initial
    begin
        int unsigned made, seg_len, budget;
        budget = TOTAL_ITEMS - DIRECTED_ITEMS;
        send_gap_pct = 23;
        recv_gap_pct = 78;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-frame sheet straight out of reset.
        queue_item(MODE_TICK, 16'd7);
        queue_item(MODE_START, 16'd0);
        queue_item(MODE_TICK, 16'd0);
        queue_item(MODE_TICK, 16'hFFFF);
        queue_item(MODE_TICK, 16'd1);
        for (int m = MODE_RESUME + 1; m <= MODE_TOP; m++)
            queue_item(m[2:0], 16'hFFFF);
        queue_item(MODE_RESUME, 16'd0);
        queue_item(MODE_PAUSE, 16'd0);
        queue_item(MODE_RESUME, 16'd0);
        queue_item(MODE_STOP, 16'd0);
        wait_idle();

        // Largest sheet, reversed looping range from the top, zero period.
        program_sheet(31, 16, 1023, 1023, 255, 0, FLAG_RANGE | FLAG_LOOP | FLAG_REVERSE, 0);
        queue_item(MODE_START, 16'd0);
        queue_item(MODE_TICK, 16'd0);
        queue_item(MODE_TICK, 16'hFFFF);
        queue_item(MODE_TICK, 16'd1);
        queue_item(MODE_PAUSE, 16'd0);
        queue_item(MODE_TICK, 16'd3);
        queue_item(MODE_RESUME, 16'd0);
        queue_item(MODE_STOP, 16'd0);
        wait_idle();

        // Zero-sized sheet with the longest period.
        program_sheet(0, 0, 0, 0, 0, 0, 0, 65535);
        queue_item(MODE_START, 16'd0);
        queue_item(MODE_TICK, 16'hFFFF);
        queue_item(MODE_TICK, 16'hFFFF);
        queue_item(MODE_RESUME, 16'd0);
        queue_item(MODE_TICK, 16'd0);

        made = 0;
        while (made < budget)
        begin
            wait_idle();
            if (made < budget / 3)
            begin
                send_gap_pct = 23;
                recv_gap_pct = 78;
            end
            else if (made < 2 * budget / 3)
            begin
                send_gap_pct = 78;
                recv_gap_pct = 23;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            random_sheet();
            seg_len = $urandom_range(30, 90);
            if ($urandom_range(99) < 80)
                queue_item(MODE_START, 16'($urandom));
            for (int k = 0; k < seg_len; k++)
                pending = {pending, random_command()};
            made += seg_len;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d commands across %0d register settings (%0d register writes).",
                 cmds_taken, settings_used, cfg_writes);
        $display("Checked %0d frames, %0d of them ending a one-shot play.",
                 frames_seen, plays_ended);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
